### sv/rse_pkg.sv
// rse_pkg: shared types and constants for the RPN stack evaluator.
// Token modes, error codes, controller states and the command/status
// structs between rse_ctrl and rse_dp. No dependencies.
package rse_pkg;

  localparam int DATA_W = 32;
  localparam int DIV_CNT_W = 5;   // counts the 32 quotient bits

  typedef enum logic [3:0] {
    MODE_PUSH   = 4'd0,
    MODE_ADD    = 4'd1,
    MODE_SUB    = 4'd2,
    MODE_MUL    = 4'd3,
    MODE_DIV    = 4'd4,
    MODE_NEG    = 4'd5,
    MODE_IF     = 4'd6,
    MODE_MIN    = 4'd7,
    MODE_MAX    = 4'd8,
    MODE_FINISH = 4'd9
  } mode_t;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DIV0 = 2'd1;
  localparam logic [1:0] ERR_OVF  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_REQ,
    S_POP_CAP,
    S_EXEC,
    S_DIV,
    S_DIV_FIX,
    S_WB,
    S_FIN_REQ,
    S_FIN_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic pop_req;
    logic pop_cap;
    logic exec;
    logic div_step;
    logic div_fix;
    logic wb;
    logic fin_read;
    logic fin_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] mode;
    logic       aborted;
    logic       last_pop;
    logic       x_zero;
    logic       div_last;
    logic       out_free;
  } dp_stat_t;

endpackage

### sv/rse_ctrl.sv
// rse_ctrl: token sequencer for the RPN stack evaluator.
// Drives dp_cmd_t commands into rse_dp from its status; uses rse_pkg.
module rse_ctrl
  import rse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        priority if (stat.mode == MODE_FINISH) begin
          state_nxt = S_FIN_REQ;
        end else if (stat.aborted) begin
          state_nxt = S_IDLE;
        end else begin
          unique case (stat.mode)
            MODE_PUSH: state_nxt = S_EXEC;
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV,
            MODE_NEG, MODE_IF, MODE_MIN, MODE_MAX: state_nxt = S_POP_REQ;
            default: state_nxt = S_IDLE;   // unused modes do nothing
          endcase
        end
      end
      S_POP_REQ: state_nxt = S_POP_CAP;
      S_POP_CAP: begin
        state_nxt = stat.last_pop ? S_EXEC : S_POP_REQ;
      end
      S_EXEC: begin
        priority if (stat.mode == MODE_MUL) begin
          state_nxt = S_WB;
        end else if (stat.mode == MODE_DIV && !stat.x_zero) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (stat.div_last) state_nxt = S_DIV_FIX;
      end
      S_DIV_FIX: state_nxt = S_WB;
      S_WB:      state_nxt = S_IDLE;
      S_FIN_REQ: state_nxt = S_FIN_OUT;
      S_FIN_OUT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_POP_REQ: cmd.pop_req  = 1'b1;
      S_POP_CAP: cmd.pop_cap  = 1'b1;
      S_EXEC:    cmd.exec     = 1'b1;
      S_DIV:     cmd.div_step = 1'b1;
      S_DIV_FIX: cmd.div_fix  = 1'b1;
      S_WB:      cmd.wb       = 1'b1;
      S_FIN_REQ: cmd.fin_read = 1'b1;
      S_FIN_OUT: cmd.fin_emit = stat.out_free;
      default: ;
    endcase
  end

endmodule

### sv/rse_dp.sv
// rse_dp: datapath of the RPN stack evaluator: value stack memory, stack
// pointer, operand registers, ALU, multiplier, serial divider and result
// register. Commanded by rse_ctrl; uses rse_pkg.
module rse_dp
  import rse_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        in_mode,
  input  logic [DATA_W-1:0] in_operand_value,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_result_value,
  output logic [1:0]        out_error_code
);

  localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int CW   = $clog2(STACK_DEPTH + 2);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [DATA_W-1:0] wr_data;

  logic [3:0]        mode_r;
  logic [DATA_W-1:0] opv_r;
  logic [SP_W-1:0]   sp_r;
  logic [SP_W-1:0]   sp_dec;
  logic              sp_nz;
  logic              sp_full;
  logic [1:0]        abort_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     cnt_load;
  logic [CW-1:0]     n_clamp;
  logic              pop_nz_r;
  logic              first_r;
  logic [DATA_W-1:0] op0_r, op1_r, op2_r;
  logic [DATA_W-1:0] pop_val;
  logic [DATA_W-1:0] best;
  logic              is_minmax;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] res_r;

  logic [DATA_W-1:0]    div_r;
  logic [DATA_W-1:0]    quo_r;
  logic [DATA_W:0]      rem_r;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      rem_diff;
  logic [DIV_CNT_W-1:0] dcnt_r;
  logic                 neg_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  logic [1:0]        out_err_r;
  logic              out_free;

  assign sp_dec    = sp_r - SP_W'(1);
  assign sp_nz     = (sp_r != '0);
  assign sp_full   = (sp_r == SP_W'(STACK_DEPTH));
  assign is_minmax = (mode_r == MODE_MIN) || (mode_r == MODE_MAX);
  assign pop_val   = pop_nz_r ? rd_data_r : '0;
  assign out_free  = !out_valid_r || !out_stall;

  // MIN/MAX pop count: n pops (at least one), but never more than the stack plus one zero
  always_comb begin
    priority if ($signed(in_operand_value) <= 32'sd1) begin
      n_clamp = CW'(1);
    end else if (in_operand_value > 32'(STACK_DEPTH + 1)) begin
      n_clamp = CW'(STACK_DEPTH + 1);
    end else begin
      n_clamp = in_operand_value[CW-1:0];
    end
  end

  always_comb begin
    unique case (in_mode)
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: cnt_load = CW'(2);
      MODE_NEG:                               cnt_load = CW'(1);
      MODE_IF:                                cnt_load = CW'(3);
      MODE_MIN, MODE_MAX:                     cnt_load = n_clamp;
      default:                                cnt_load = '0;
    endcase
  end

  // running min/max
  always_comb begin
    best = op0_r;
    if (first_r) begin
      best = pop_val;
    end else if (mode_r == MODE_MAX) begin
      if ($signed(op0_r) < $signed(pop_val)) best = pop_val;
    end else begin
      if ($signed(pop_val) < $signed(op0_r)) best = pop_val;
    end
  end

  // op0 = y (second pop), op1 = x (first pop); IF: op0 = c, op1 = t, op2 = f
  always_comb begin
    unique case (mode_r)
      MODE_PUSH: alu_res = opv_r;
      MODE_ADD:  alu_res = op0_r + op1_r;
      MODE_SUB:  alu_res = op0_r - op1_r;
      MODE_NEG:  alu_res = '0 - op0_r;
      MODE_IF:   alu_res = (op0_r != '0 && !op0_r[DATA_W-1]) ? op1_r : op2_r;
      MODE_MIN, MODE_MAX: alu_res = op0_r;
      default:   alu_res = '0;
    endcase
  end

  // stack port control
  always_comb begin
    rd_en   = (cmd.pop_req || cmd.fin_read) && sp_nz;
    rd_addr = sp_dec[AW-1:0];
    wr_en   = 1'b0;
    wr_data = alu_res;
    if (cmd.wb) begin
      wr_en   = 1'b1;
      wr_data = res_r;
    end else if (cmd.exec) begin
      unique case (mode_r)
        MODE_PUSH: wr_en = !sp_full;
        MODE_ADD, MODE_SUB, MODE_NEG, MODE_IF, MODE_MIN, MODE_MAX: wr_en = 1'b1;
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[sp_r[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // divider step: restoring, one quotient bit per cycle
  assign rem_sh   = {rem_r[DATA_W-1:0], quo_r[DATA_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      abort_r     <= ERR_NONE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        cnt_r <= cnt_load;
      end else if (cmd.pop_req && !sp_nz && is_minmax) begin
        cnt_r <= CW'(1);   // only zeros remain: one more compare finishes it
      end else if (cmd.pop_cap) begin
        cnt_r <= cnt_r - CW'(1);
      end

      priority if (cmd.fin_emit) begin
        sp_r <= '0;
      end else if (rd_en && cmd.pop_req) begin
        sp_r <= sp_dec;
      end else if (wr_en) begin
        sp_r <= sp_r + SP_W'(1);
      end

      priority if (cmd.fin_emit) begin
        abort_r <= ERR_NONE;
      end else if (cmd.exec && mode_r == MODE_PUSH && sp_full) begin
        abort_r <= ERR_OVF;
      end else if (cmd.exec && mode_r == MODE_DIV && op1_r == '0) begin
        abort_r <= ERR_DIV0;
      end

      if (cmd.fin_emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r  <= in_mode;
      opv_r   <= in_operand_value;
      first_r <= 1'b1;
    end
    if (cmd.pop_req) begin
      pop_nz_r <= sp_nz;
    end
    if (cmd.pop_cap) begin
      first_r <= 1'b0;
      if (is_minmax) begin
        op0_r <= best;
      end else begin
        op0_r <= pop_val;
        op1_r <= op0_r;
        op2_r <= op1_r;
      end
    end
    if (cmd.exec && mode_r == MODE_MUL) begin
      res_r <= op0_r * op1_r;
    end
    if (cmd.exec && mode_r == MODE_DIV) begin
      div_r  <= op1_r[DATA_W-1] ? ('0 - op1_r) : op1_r;
      quo_r  <= op0_r[DATA_W-1] ? ('0 - op0_r) : op0_r;
      rem_r  <= '0;
      dcnt_r <= DIV_CNT_W'(DATA_W - 1);
      neg_r  <= op0_r[DATA_W-1] ^ op1_r[DATA_W-1];
    end
    if (cmd.div_step) begin
      dcnt_r <= dcnt_r - DIV_CNT_W'(1);
      if (!rem_diff[DATA_W]) begin
        rem_r <= rem_diff;
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
    if (cmd.div_fix) begin
      res_r <= neg_r ? ('0 - quo_r) : quo_r;
    end
    if (cmd.fin_emit) begin
      out_value_r <= (abort_r == ERR_NONE && sp_nz) ? rd_data_r : '0;
      out_err_r   <= abort_r;
    end
  end

  always_comb begin
    stat.mode     = mode_r;
    stat.aborted  = (abort_r != ERR_NONE);
    stat.last_pop = (cnt_r == CW'(1));
    stat.x_zero   = (op1_r == '0);
    stat.div_last = (dcnt_r == '0);
    stat.out_free = out_free;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_error_code   = out_err_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !sp_full)
    else $error("stack write while full");

  a_no_write_abort: assert property (@(posedge clk) disable iff (!rst_n)
    (abort_r != ERR_NONE) |-> !wr_en)
    else $error("stack write in aborted expression");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_emit |=> out_valid_r && (sp_r == '0) && (abort_r == ERR_NONE))
    else $error("finish did not emit and clear");

endmodule

### sv/rpn_stack_evaluator_core.sv
// RPN stack evaluator: one pre-parsed token per request, one result per finish.
// Per token: DECODE, then push goes to EXEC; ignored tokens (unused modes, aborted
// expression) go back to IDLE; operators run POP_REQ/POP_CAP once per pop (pops: 1 neg,
// 2 binary, 3 IF, up to min(n, depth+1) for MIN/MAX) and then EXEC; mul adds WB, div
// adds the serial divider (DIV, DIV_FIX, WB) unless the divisor is zero. Finish:
// FIN_REQ reads the top; FIN_OUT waits until the result register is free, loads it
// and returns to IDLE. Cost is set by the stack memory (registered read) and divider.
// Synchronous active-low reset empties the stack and clears the abort status.
module rpn_stack_evaluator_core
  import rse_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_mode,
  input  logic signed [31:0] in_operand_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_error_code
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [DATA_W-1:0] result_u;

  rse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  rse_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mode          (in_mode),
    .in_operand_value ($unsigned(in_operand_value)),
    .cmd              (cmd),
    .stat             (stat),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_result_value (result_u),
    .out_error_code   (out_error_code)
  );

  assign out_result_value = $signed(result_u);

endmodule
